>>> hw/rtl/framed_command_receiver_crc16_macros.svh
// assertion macros shared by the checker files
`ifndef FRAMED_COMMAND_RECEIVER_CRC16_MACROS_SVH
`define FRAMED_COMMAND_RECEIVER_CRC16_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FCR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcr implication check failed");

// next-cycle implication, disabled while reset is low
`define FCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcr next-cycle check failed");

`endif

>>> hw/rtl/fcr_pkg.sv
// ----------------------------------------------------------------------------
// fcr_pkg
// shared types, constants and the crc-16-ccitt byte step
// ----------------------------------------------------------------------------
package fcr_pkg;

    localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND = 8'h55;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] FULL_SCALE  = 16'd36000;
    localparam logic signed [16:0] HALF_SCALE = 17'sd18000;
    localparam logic [7:0]  MAX_TYPE    = 8'd3;
    localparam logic [1:0]  CMD_Z_RATE  = 2'd3;
    localparam logic [1:0]  PAY_LAST    = 2'd2;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_BODY  = 3'd2,
        PH_CRCLO = 3'd3,
        PH_CRCHI = 3'd4
    } t_phase;

    typedef struct packed {
        logic                valid;
        logic [1:0]          cmd_type;
        logic signed [16:0]  cmd_value;
    } t_result;

    // one byte through the crc, msb first, eight shift steps
    function automatic logic [15:0] crc16_feed(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/fcr_parser.sv
// ----------------------------------------------------------------------------
// fcr_parser
// input beat register, frame state machine, running crc and result decode
// ----------------------------------------------------------------------------
module fcr_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_out_free,
    output fcr_pkg::t_result o_res
);
    import fcr_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    t_phase      r_phase;
    t_phase      n_phase;
    logic [7:0]  r_pay [3];
    logic [1:0]  r_count;
    logic [1:0]  n_count;
    logic [7:0]  r_crc_lo;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic        adv;
    logic        accept;

    logic [15:0]        rcv_crc;
    logic [15:0]        raw;
    logic [15:0]        clamped;
    logic signed [16:0] value;
    logic               frame_ok;

    // only the crc-high beat can produce a result, so only it waits on the output
    assign adv     = !(r_phase == PH_CRCHI) || i_out_free;
    assign o_stall = r_in_valid && !adv;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_SYNC2: n_phase = (r_in_byte == SYNC_SECOND) ? PH_BODY : PH_SYNC1;
            PH_BODY:  n_phase = (r_count == PAY_LAST) ? PH_CRCLO : PH_BODY;
            PH_CRCLO: n_phase = PH_CRCHI;
            PH_CRCHI: n_phase = PH_SYNC1;
            default:  n_phase = (r_in_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
        endcase
    end

    // datapath and result
    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        unique case (r_phase)
            PH_SYNC2: begin
                if (r_in_byte == SYNC_SECOND) begin
                    n_count = 2'd0;
                    n_crc   = CRC_INIT;
                end
            end
            PH_BODY: begin
                n_crc   = crc16_feed(r_crc, r_in_byte);
                n_count = (r_count == PAY_LAST) ? 2'd0 : r_count + 2'd1;
            end
            default: begin
            end
        endcase

        rcv_crc  = {r_in_byte, r_crc_lo};
        frame_ok = (rcv_crc == r_crc) && (r_pay[0] <= MAX_TYPE);
        raw      = {r_pay[2], r_pay[1]};
        clamped  = (raw > FULL_SCALE) ? FULL_SCALE : raw;
        value    = signed'({1'b0, clamped});
        if ((r_pay[0][1:0] == CMD_Z_RATE) && (value > HALF_SCALE)) begin
            value = HALF_SCALE - value;
        end

        o_res.valid     = r_in_valid && (r_phase == PH_CRCHI) && frame_ok;
        o_res.cmd_type  = r_pay[0][1:0];
        o_res.cmd_value = value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SYNC1;
            r_count  <= 2'd0;
            r_crc_lo <= 8'h00;
            r_crc    <= CRC_INIT;
        end else if (r_in_valid && adv) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_crc   <= n_crc;
            if (r_phase == PH_CRCLO) begin
                r_crc_lo <= r_in_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && adv && (r_phase == PH_BODY)) begin
            r_pay[r_count] <= r_in_byte;
        end
    end

endmodule

>>> hw/rtl/fcr_out_reg.sv
// ----------------------------------------------------------------------------
// fcr_out_reg
// result register holding one command until the consumer takes it
// ----------------------------------------------------------------------------
module fcr_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fcr_pkg::t_result   i_res,
    output logic               o_out_free,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_cmd_type,
    output logic signed [16:0] o_cmd_value
);
    import fcr_pkg::*;

    logic               r_valid;
    logic [1:0]         r_type;
    logic signed [16:0] r_value;

    assign o_out_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_out_free) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out_free && i_res.valid) begin
            r_type  <= i_res.cmd_type;
            r_value <= i_res.cmd_value;
        end
    end

    assign o_valid     = r_valid;
    assign o_cmd_type  = r_type;
    assign o_cmd_value = r_value;

endmodule

>>> hw/rtl/framed_command_receiver_crc16.sv
// result path: the last crc byte passes the input beat register, then the command is registered onto o_valid
// throughput: one byte per cycle; the crc-high beat waits only while a result sits stalled
// frame cost: 7 bytes per command (2 sync, 3 payload, 2 crc), each crc step unrolled into combinational logic
// reset: synchronous active-low i_rst_n; hunts for sync, crc at 0xffff, no result pending
// ----------------------------------------------------------------------------
// framed_command_receiver_crc16
// sync-framed command parser with crc-16-ccitt check, clamp and rate remap
// ----------------------------------------------------------------------------
module framed_command_receiver_crc16 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // receive byte channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,
    // command channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_cmd_type,
    output logic signed [16:0] o_cmd_value
);
    import fcr_pkg::*;

    // decoded result from the parser, valid only on a good frame end
    t_result res;
    // result register can take a new command this cycle
    logic    out_free;

    // stage 1: input beat register plus frame decode
    // the state machine walks sync1 -> sync2 -> body x3 -> crc lo -> crc hi,
    // a bad second sync byte drops back to hunting without re-checking itself
    fcr_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_rx_byte  (i_rx_byte),
        .i_out_free (out_free),
        .o_res      (res)
    );

    // stage 2: command register, decouples the consumer's stall from the byte stream
    fcr_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (res),
        .o_out_free  (out_free),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_cmd_type  (o_cmd_type),
        .o_cmd_value (o_cmd_value)
    );

endmodule

>>> hw/rtl/fcr_checker.sv
// ----------------------------------------------------------------------------
// fcr_checker
// port-level checks on the command receiver
// ----------------------------------------------------------------------------
`include "framed_command_receiver_crc16_macros.svh"

module fcr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [1:0]         o_cmd_type,
    input logic signed [16:0] o_cmd_value
);
    import fcr_pkg::*;

    logic in_beat;
    assign in_beat = i_valid && !o_stall;

    `FCR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_cmd_type) && $stable(o_cmd_value))
    `FCR_ASSERT_IMPLY(a_angle_range, i_clk, i_rst_n, o_valid && (o_cmd_type != CMD_Z_RATE), !o_cmd_value[16] && (o_cmd_value <= 17'sd36000))
    `FCR_ASSERT_IMPLY(a_rate_range, i_clk, i_rst_n, o_valid && (o_cmd_type == CMD_Z_RATE), (o_cmd_value >= -17'sd18000) && (o_cmd_value <= HALF_SCALE))
    `FCR_ASSERT_IMPLY(a_result_needs_beat, i_clk, i_rst_n, $rose(o_valid), $past(in_beat, 2))

endmodule

bind framed_command_receiver_crc16 fcr_checker u_fcr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_cmd_type  (o_cmd_type),
    .o_cmd_value (o_cmd_value)
);

>>> test/tb_framed_command_receiver_crc16.sv
// ----------------------------------------------------------------------------
// tb_framed_command_receiver_crc16
// self-checking bench for the sync-framed crc-16 command receiver
//
// Bytes are streamed into the receiver as whole frames, broken frames and
// noise. A byte-level model of the frame parser runs on every accepted beat
// and queues the command it expects. Each command beat leaving the block is
// compared with the oldest queued command. The sender works in random
// bursts and the command side stalls in its own rhythm. Some stretches have
// no idling at all.
// ----------------------------------------------------------------------------
module tb_framed_command_receiver_crc16;
    timeunit 1ns;
    timeprecision 1ps;

    import fcr_pkg::*;

    localparam int     CLK_HALF      = 4;
    localparam int     RESET_CYCLES  = 11;
    localparam int     DRAIN_CYCLES  = 8;
    localparam longint CYCLE_LIMIT   = 300000;

    typedef enum int {
        FLAW_NONE,
        FLAW_CRC,
        FLAW_SYNC,
        FLAW_SHORT
    } t_frame_flaw;

    typedef enum int {
        SINK_READY,
        SINK_SPARSE,
        SINK_RUNS
    } t_sink_mode;

    typedef struct {
        logic [1:0]         typ;
        logic signed [16:0] value;
    } t_command;

    // dut inputs, all known from time zero
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    logic [7:0]         i_rx_byte   = 8'h00;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    logic [1:0]         o_cmd_type;
    logic signed [16:0] o_cmd_value;

    // frame parser model state
    t_phase      rx_phase    = PH_SYNC1;
    logic [7:0]  body_bytes [3];
    logic [1:0]  body_count  = 2'd0;
    logic [7:0]  crc_lo_seen = 8'h00;
    logic [15:0] crc_acc     = CRC_INIT;

    // commands the parser has decoded but the block has not yet delivered
    t_command    pending_cmds [$];

    // traffic shaping
    bit          gaps_on     = 1'b0;
    int          burst_left  = 0;
    t_sink_mode  sink_mode   = SINK_READY;
    int          stall_run   = 0;

    // bookkeeping
    int          error_count = 0;
    int          bytes_sent  = 0;
    int          frames_sent = 0;
    int          cmds_seen   = 0;
    longint      cycle_count = 0;

    framed_command_receiver_crc16 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_cmd_type  (o_cmd_type),
        .o_cmd_value (o_cmd_value)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // crc-16-ccitt, one input bit at a time into the feedback tap
    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] acc,
                                                   input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // advance the frame parser by one byte, queue a command when a frame closes
    function automatic void decode_rx_byte(input logic [7:0] b);
        t_command    cmd;
        logic [16:0] raw;
        case (rx_phase)
            PH_SYNC2: begin
                if (b == SYNC_SECOND) begin
                    body_count = 2'd0;
                    crc_acc    = CRC_INIT;
                    rx_phase   = PH_BODY;
                end else begin
                    // a bad second sync byte never counts as a fresh first one
                    rx_phase = PH_SYNC1;
                end
            end
            PH_BODY: begin
                body_bytes[body_count] = b;
                crc_acc = crc_ccitt_step(crc_acc, b);
                if (body_count == PAY_LAST) begin
                    body_count = 2'd0;
                    rx_phase   = PH_CRCLO;
                end else begin
                    body_count = body_count + 2'd1;
                end
            end
            PH_CRCLO: begin
                crc_lo_seen = b;
                rx_phase    = PH_CRCHI;
            end
            PH_CRCHI: begin
                rx_phase = PH_SYNC1;
                // crc travels low byte first; unknown types are dropped quietly
                if ({b, crc_lo_seen} == crc_acc && body_bytes[0] <= MAX_TYPE) begin
                    raw = {1'b0, body_bytes[2], body_bytes[1]};
                    if (raw > FULL_SCALE) begin
                        raw = {1'b0, FULL_SCALE};
                    end
                    cmd.typ   = body_bytes[0][1:0];
                    cmd.value = signed'(raw);
                    // z rate folds the upper half of the range into negatives
                    if (cmd.typ == CMD_Z_RATE && cmd.value > HALF_SCALE) begin
                        cmd.value = HALF_SCALE - cmd.value;
                    end
                    pending_cmds.push_back(cmd);
                end
            end
            default: begin
                if (b == SYNC_FIRST) begin
                    rx_phase = PH_SYNC2;
                end else begin
                    rx_phase = PH_SYNC1;
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // model update on each input beat, then check of each command beat
    always @(posedge i_clk) begin
        t_command want;
        if (i_rst_n && i_valid && !o_stall) begin
            decode_rx_byte(i_rx_byte);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            cmds_seen++;
            if (pending_cmds.size() == 0) begin
                report_mismatch("command with none pending, type", o_cmd_type, -1);
            end else begin
                want = pending_cmds.pop_front();
                if (o_cmd_type !== want.typ) begin
                    report_mismatch("cmd_type", o_cmd_type, want.typ);
                end
                if (o_cmd_value !== want.value) begin
                    report_mismatch("cmd_value", o_cmd_value, want.value);
                end
            end
        end
    end

    // command side back-pressure: off, scattered, or long on/off runs
    always @(posedge i_clk) begin
        case (sink_mode)
            SINK_READY: begin
                i_stall <= 1'b0;
            end
            SINK_SPARSE: begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                if (stall_run == 0) begin
                    i_stall   <= !i_stall;
                    stall_run = $urandom_range(1, 10);
                end else begin
                    stall_run--;
                end
            end
        endcase
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d commands still pending",
                     cycle_count, pending_cmds.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one input beat; valid stays high across back-to-back bytes in a burst
    task automatic send_byte(input logic [7:0] b);
        if (gaps_on) begin
            if (burst_left == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    // full or damaged frame: sync pair, type, value lo/hi, crc lo/hi
    task automatic send_frame(input logic [7:0] typ, input logic [15:0] value,
                              input t_frame_flaw flaw);
        logic [7:0]  fbytes [7];
        logic [15:0] crc;
        int          n;
        crc = crc_ccitt_step(CRC_INIT, typ);
        crc = crc_ccitt_step(crc, value[7:0]);
        crc = crc_ccitt_step(crc, value[15:8]);
        if (flaw == FLAW_CRC) begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        fbytes = '{SYNC_FIRST, SYNC_SECOND, typ, value[7:0], value[15:8],
                   crc[7:0], crc[15:8]};
        if (flaw == FLAW_SYNC) begin
            do fbytes[1] = 8'($urandom_range(0, 255));
            while (fbytes[1] == SYNC_SECOND);
        end
        // a short frame stops somewhere inside the body or the crc
        n = (flaw == FLAW_SHORT) ? $urandom_range(3, 6) : 7;
        for (int k = 0; k < n; k++) begin
            send_byte(fbytes[k]);
        end
        frames_sent++;
    endtask

    // values lean on the clamp and remap boundaries
    function automatic logic [15:0] pick_value();
        logic [15:0] corners [8] = '{16'd0, 16'd1, 16'd18000, 16'd18001,
                                     16'd35999, 16'd36000, 16'd36001, 16'hFFFF};
        case ($urandom_range(0, 3))
            0: return corners[$urandom_range(0, 7)];
            1: return 16'($urandom);
            default: return 16'($urandom_range(0, 36000));
        endcase
    endfunction

    function automatic logic [7:0] pick_type();
        if ($urandom_range(0, 9) == 0) begin
            return 8'($urandom_range(4, 255));
        end
        return 8'($urandom_range(0, 3));
    endfunction

    // the three angle commands, clamp at full scale and all-zero/all-one bytes
    task automatic test_angle_commands();
        send_frame(8'd0, 16'hFFFF, FLAW_NONE);
        send_frame(8'd1, 16'h0000, FLAW_NONE);
        send_frame(8'd2, 16'd36001, FLAW_NONE);
    endtask

    // z rate: clamped to full scale, then folded down to the negative limit
    task automatic test_rate_command();
        send_frame(8'd3, 16'hFFFF, FLAW_NONE);
    endtask

    // frames that must vanish without a command
    task automatic test_dropped_frames();
        // lone first sync byte, so the frame's own 0xaa lands as a bad second sync
        send_byte(SYNC_FIRST);
        send_frame(8'd0, 16'd1234, FLAW_NONE);
        send_frame(8'd1, 16'd4321, FLAW_CRC);
        send_frame(8'd4, 16'd100, FLAW_NONE);
    endtask

    // mostly clean frames with random content, plus damaged frames and noise
    task automatic test_random_traffic(input int n_bytes);
        int target;
        int sel;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                send_frame(pick_type(), pick_value(), FLAW_NONE);
            end else if (sel < 85) begin
                send_frame(pick_type(), pick_value(), t_frame_flaw'($urandom_range(1, 3)));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_byte(SYNC_FIRST);
                    end else begin
                        send_byte(8'($urandom_range(0, 255)));
                    end
                end
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames under bursty input and long result stalls
        gaps_on   = 1'b1;
        sink_mode = SINK_RUNS;
        test_angle_commands();
        test_rate_command();
        test_dropped_frames();

        // random traffic: full rate first, then two idling patterns
        gaps_on   = 1'b0;
        sink_mode = SINK_READY;
        test_random_traffic(500);
        gaps_on   = 1'b1;
        sink_mode = SINK_SPARSE;
        test_random_traffic(450);
        sink_mode = SINK_RUNS;
        test_random_traffic(450);
        i_valid <= 1'b0;

        // let the last commands drain, then a few quiet cycles for stragglers
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("streamed %0d bytes in %0d frames plus noise, %0d commands checked",
                 bytes_sent, frames_sent, cmds_seen);
        $display("%0d field mismatches over %0d cycles", error_count, cycle_count);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
